/* rtl/ubre_pkg.sv */
package ubre_pkg;

  // block geometry
  localparam int BLOCK_BYTES = 32;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);

  // stream markers
  localparam logic [7:0] MARK_UNIFORM = 8'h00;
  localparam logic [7:0] MARK_RAW     = 8'hFF;
  localparam logic [7:0] MARK_PARTIAL = 8'hFE;

  // kinds of block encoding
  localparam logic [1:0] KIND_UNIFORM = 2'd0;
  localparam logic [1:0] KIND_RAW     = 2'd1;
  localparam logic [1:0] KIND_PARTIAL = 2'd2;

  // request from the block tracker to the emitter
  typedef struct packed {
    logic             start;
    logic [1:0]       kind;
    logic [CNT_W-1:0] len;
    logic [7:0]       val;
    logic             last;
  } job_t;

endpackage

/* rtl/ubre_buf.sv */
module ubre_buf
  import ubre_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BLOCK_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ubre_blk.sv */
module ubre_blk
  import ubre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              seq_busy,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output job_t              job
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic             all_same;
  logic             all_same_next;
  logic [7:0]       first_byte;
  logic [7:0]       first_byte_next;
  logic             acc;
  logic [CNT_W-1:0] fill_inc;
  logic             same;
  logic [7:0]       blk_first;
  logic             full;

  assign in_ready = !seq_busy;
  assign acc      = in_valid && in_ready;

  // buffer write of the incoming word
  assign wr_en   = acc;
  assign wr_addr = fill[ADDR_W-1:0];
  assign wr_data = in_byte;

  // block tracking
  assign fill_inc  = fill + CNT_W'(1);
  assign blk_first = (fill == '0) ? in_byte : first_byte;
  assign same      = (fill == '0) || (all_same && (in_byte == first_byte));
  assign full      = (fill_inc == CNT_W'(BLOCK_BYTES));

  always_comb begin
    fill_next       = fill;
    all_same_next   = all_same;
    first_byte_next = first_byte;
    job.start       = 1'b0;
    job.kind        = KIND_PARTIAL;
    job.len         = fill_inc;
    job.val         = blk_first;
    job.last        = in_last;
    if (acc) begin
      priority if (full) begin
        job.start       = 1'b1;
        job.kind        = same ? KIND_UNIFORM : KIND_RAW;
        job.len         = CNT_W'(BLOCK_BYTES);
        fill_next       = '0;
        all_same_next   = 1'b1;
        first_byte_next = '0;
      end else if (in_last) begin
        job.start       = 1'b1;
        job.kind        = KIND_PARTIAL;
        fill_next       = '0;
        all_same_next   = 1'b1;
        first_byte_next = '0;
      end else begin
        fill_next       = fill_inc;
        all_same_next   = same;
        first_byte_next = blk_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      all_same   <= 1'b1;
      first_byte <= '0;
    end else begin
      fill       <= fill_next;
      all_same   <= all_same_next;
      first_byte <= first_byte_next;
    end
  end

endmodule

/* rtl/ubre_seq.sv */
module ubre_seq
  import ubre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  job_t              job,
  output logic              busy,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run,
  output logic              out_end
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MARK = 3'd1;
  localparam logic [2:0] S_VAL  = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [1:0]       kind;
  logic [CNT_W-1:0] len;
  logic [7:0]       val;
  logic             last;
  logic             out_free;
  logic             ld;
  logic             ld_fin;
  logic [7:0]       ld_byte;

  assign out_free = !out_valid || out_ready;
  assign busy     = (state != S_IDLE);
  // read address runs one word ahead so rd_data always matches idx
  assign rd_addr  = idx_next[ADDR_W-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    ld         = 1'b0;
    ld_fin     = 1'b0;
    ld_byte    = rd_data;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (job.start) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        if (out_free) begin
          ld = 1'b1;
          unique case (kind)
            KIND_UNIFORM: begin
              ld_byte    = MARK_UNIFORM;
              state_next = S_VAL;
            end
            KIND_RAW: begin
              ld_byte    = MARK_RAW;
              state_next = S_DATA;
            end
            default: begin
              ld_byte    = MARK_PARTIAL;
              state_next = S_CNT;
            end
          endcase
        end
      end
      S_VAL: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_fin     = 1'b1;
          ld_byte    = val;
          state_next = S_IDLE;
        end
      end
      S_CNT: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_byte    = 8'(len);
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          ld = 1'b1;
          if (idx == len - CNT_W'(1)) begin
            ld_fin     = 1'b1;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // job capture
  always_ff @(posedge clk) begin
    if (job.start && (state == S_IDLE)) begin
      kind <= job.kind;
      len  <= job.len;
      val  <= job.val;
      last <= job.last;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_byte <= ld_byte;
      out_run  <= ld_fin;
      out_end  <= ld_fin && last;
    end
  end

endmodule

/* rtl/uniform_block_rle_encoder.sv */
// Uniform-block encoder. Raw bytes gather into blocks of BLOCK_BYTES (32) in a small buffer
// memory. A full block whose bytes all match leaves as 0x00 and the byte; any other full
// block leaves as 0xFF and its bytes; a partial block at tlast leaves as 0xFE, the count and
// its bytes. A word that neither fills a block nor ends the stream is taken whenever the
// emit sequencer is idle. A word that does is followed by its encoded sequence, one output
// word per cycle while m_tready is high, with the marker loaded into the output register in
// the S_MARK state entered after the input is taken. s_tready stays low until the last word
// of the sequence is in the output register; the pace is set by the byte-wide output
// register fed from the single buffer read port under the emit sequencer.
module uniform_block_rle_encoder
  import ubre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // stream_end
);

  logic              seq_busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  job_t              job;

  // block tracking and input handshake
  ubre_blk u_blk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .seq_busy (seq_busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job      (job)
  );

  // block buffer
  ubre_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // emit sequencer and output register
  ubre_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .busy      (seq_busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_run   (m_tuser),
    .out_end   (m_tlast)
  );

endmodule
